/* rtl/core/crvc_pkg.sv */
// Package for the CNF rule vote classifier: default sizes, register and mode codes,
// and the item and pipeline tag types. No dependencies.
package crvc_pkg;

  localparam int ATTRIBUTES_DEF = 64;
  localparam int CLASSES_DEF = 8;
  localparam int FORMULAS_DEF = 8;
  localparam int CLAUSES_DEF = 8;

  localparam int CFG_W = 4;
  localparam logic [CFG_W-1:0] CLASSES_IN_USE_RESET = 4'd8;

  localparam logic REG_CLASSES_IN_USE = 1'b0;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_CLASSIFY = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [2:0]  class_select;
    logic [2:0]  formula_select;
    logic [2:0]  clause_select;
    logic [63:0] positive_mask;
    logic [63:0] negative_mask;
    logic        clause_used;
    logic        formula_present;
    logic [63:0] row_bits;
  } crvc_item_t;

  typedef struct packed {
    logic [2:0] winning_class;
    logic [3:0] winning_votes;
    logic       was_load;
  } crvc_result_t;

  typedef struct packed {
    logic valid;
    logic class_end;
    logic item_end;
  } crvc_tag_t;

endpackage

/* rtl/core/crvc_clause_bank.sv */
// Clause store: one memory bank per clause slot, addressed by formula slot, plus the
// formula present memory. Depends on crvc_pkg.
module crvc_clause_bank #(
  parameter int ATTRIBUTES = crvc_pkg::ATTRIBUTES_DEF,
  parameter int CLAUSES = crvc_pkg::CLAUSES_DEF,
  parameter int SLOTS = crvc_pkg::CLASSES_DEF * crvc_pkg::FORMULAS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       wr_en,
  input  logic                                       wr_all,
  input  logic [$clog2(SLOTS)-1:0]                   wr_addr,
  input  logic [2:0]                                 wr_clause,
  input  logic [2*ATTRIBUTES:0]                      wr_entry,
  input  logic                                       wr_present,
  input  logic [$clog2(SLOTS)-1:0]                   rd_addr,
  input  crvc_pkg::crvc_tag_t                        rd_tag,
  output logic [CLAUSES-1:0][2*ATTRIBUTES:0]         rd_rows,
  output logic                                       rd_present,
  output crvc_pkg::crvc_tag_t                        rd_tag_q
);
  import crvc_pkg::*;

  localparam int ENTRY_W = 2 * ATTRIBUTES + 1;

  logic present_mem [SLOTS];

  for (genvar b = 0; b < CLAUSES; b++) begin : g_bank
    logic [ENTRY_W-1:0] mem [SLOTS];
    logic we;

    assign we = wr_en && (wr_all || (32'(wr_clause) == b));

    always_ff @(posedge clk) begin
      if (we) begin
        mem[wr_addr] <= wr_entry;
      end
      rd_rows[b] <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      present_mem[wr_addr] <= wr_present;
    end
    rd_present <= present_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_tag_q <= '0;
    end else begin
      rd_tag_q <= rd_tag;
    end
  end

endmodule

/* rtl/core/crvc_formula_eval.sv */
// Formula evaluator: checks all clauses of one formula against the attribute row
// and registers whether the formula holds. Depends on crvc_pkg.
module crvc_formula_eval #(
  parameter int ATTRIBUTES = crvc_pkg::ATTRIBUTES_DEF,
  parameter int CLAUSES = crvc_pkg::CLAUSES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [ATTRIBUTES-1:0]              row,
  input  logic [CLAUSES-1:0][2*ATTRIBUTES:0] rows,
  input  logic                               present,
  input  crvc_pkg::crvc_tag_t                in_tag,
  output logic                               holds,
  output crvc_pkg::crvc_tag_t                out_tag
);
  import crvc_pkg::*;

  logic [CLAUSES-1:0] sat;

  always_comb begin
    for (int b = 0; b < CLAUSES; b++) begin
      sat[b] = !rows[b][2*ATTRIBUTES] ||
               (|((row & rows[b][ATTRIBUTES-1:0]) |
                  (~row & rows[b][2*ATTRIBUTES-1:ATTRIBUTES])));
    end
  end

  always_ff @(posedge clk) begin
    holds <= present && (&sat);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_tag <= '0;
    end else begin
      out_tag <= in_tag;
    end
  end

endmodule

/* rtl/core/crvc_vote_tally.sv */
// Vote tally: counts satisfied formulas per class and keeps the leading class.
// Depends on crvc_pkg.
module crvc_vote_tally #(
  parameter int CLASSES = crvc_pkg::CLASSES_DEF,
  parameter int FORMULAS_PER_CLASS = crvc_pkg::FORMULAS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     start,
  input  crvc_pkg::crvc_tag_t                      in_tag,
  input  logic                                     holds,
  output logic                                     done,
  output logic [$clog2(CLASSES)-1:0]               best_class,
  output logic [$clog2(FORMULAS_PER_CLASS+1)-1:0]  best_votes
);
  import crvc_pkg::*;

  localparam int CLS_W = $clog2(CLASSES);
  localparam int VOTE_W = $clog2(FORMULAS_PER_CLASS + 1);

  logic [CLS_W-1:0]  cls;
  logic [VOTE_W-1:0] votes;
  logic [VOTE_W-1:0] votes_next;

  assign votes_next = votes + VOTE_W'(holds);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      cls <= '0;
      votes <= '0;
      best_class <= '0;
      best_votes <= '0;
    end else begin
      done <= !start && in_tag.valid && in_tag.item_end;
      if (start) begin
        cls <= '0;
        votes <= '0;
        best_class <= '0;
        best_votes <= '0;
      end else if (in_tag.valid) begin
        if (in_tag.class_end) begin
          if (votes_next > best_votes) begin
            best_votes <= votes_next;
            best_class <= cls;
          end
          votes <= '0;
          cls <= cls + CLS_W'(1);
        end else begin
          votes <= votes_next;
        end
      end
    end
  end

endmodule

/* rtl/core/cnf_rule_vote_classifier_unit.sv */
// Top level of the CNF rule vote classifier: sequencer, configuration port and
// result register. Depends on crvc_pkg, crvc_clause_bank, crvc_formula_eval and
// crvc_vote_tally.
//
// Items arrive on the item channel (valid/ready). A load item writes one clause
// slot and the present flag of its formula and is acknowledged with was_load set.
// A classify item scores every class in use, one formula slot per cycle through a
// shared evaluator that checks all clauses of the formula at once, and returns the
// class with the most satisfied formulas. A classify item issues its formula slots in
// order, waits in the drain state until the tally is done and then finishes; with no
// class in use it goes straight to the finish state, as a load item does. The result
// is registered in the same cycle as the block becomes ready for the next item.
// Results wait in an output register; the block takes the next item while a result
// is stalled, but holds a new result back until the register is free.
// After reset a clearing pass over all CLASSES*FORMULAS_PER_CLASS slots (64 by default)
// clears the clause used and formula present flags; no item is taken meanwhile.
// classes_in_use is written through the APB port at any time the block is idle.
module cnf_rule_vote_classifier_unit #(
  parameter int ATTRIBUTES = crvc_pkg::ATTRIBUTES_DEF,
  parameter int CLASSES = crvc_pkg::CLASSES_DEF,
  parameter int FORMULAS_PER_CLASS = crvc_pkg::FORMULAS_DEF,
  parameter int CLAUSES_PER_FORMULA = crvc_pkg::CLAUSES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_ready,
  input  crvc_pkg::crvc_item_t   item,
  output logic                   result_valid,
  input  logic                   result_ready,
  output crvc_pkg::crvc_result_t result,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  import crvc_pkg::*;

  localparam int FORMULA_SLOTS = CLASSES * FORMULAS_PER_CLASS;
  localparam int FSLOT_W = $clog2(FORMULA_SLOTS);
  localparam int FRM_W = (FORMULAS_PER_CLASS > 1) ? $clog2(FORMULAS_PER_CLASS) : 1;
  localparam int CLS_W = $clog2(CLASSES);
  localparam int NCLS_W = $clog2(CLASSES + 1);
  localparam int VOTE_W = $clog2(FORMULAS_PER_CLASS + 1);
  localparam int ENTRY_W = 2 * ATTRIBUTES + 1;

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_ISSUE  = 5'b00100,
    S_DRAIN  = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t state;
  logic [FSLOT_W-1:0] addr;
  logic [FRM_W-1:0] frm;
  logic [CLS_W-1:0] cls;
  logic [NCLS_W-1:0] ncls;
  logic [ATTRIBUTES-1:0] row;
  logic [2:0] res_class;
  logic [3:0] res_votes;
  logic res_load;
  logic [CFG_W-1:0] classes_in_use;

  logic accept;
  logic cfg_write;
  logic [NCLS_W-1:0] n_eff;
  logic load_ok;
  logic [FSLOT_W-1:0] load_fslot;
  logic wr_en;
  logic wr_all;
  logic [FSLOT_W-1:0] wr_addr;
  logic [ENTRY_W-1:0] wr_entry;
  logic wr_present;
  crvc_tag_t issue_tag;
  crvc_tag_t bank_tag;
  crvc_tag_t eval_tag;
  logic [CLAUSES_PER_FORMULA-1:0][ENTRY_W-1:0] bank_rows;
  logic bank_present;
  logic holds;
  logic tally_done;
  logic tally_start;
  logic [CLS_W-1:0] best_class;
  logic [VOTE_W-1:0] best_votes;
  logic [31:0] best_class_ext;
  logic [31:0] best_votes_ext;
  logic out_free;

  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_CLASSES_IN_USE) ? 32'(classes_in_use) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      classes_in_use <= CLASSES_IN_USE_RESET;
    end else if (cfg_write && paddr[2] == REG_CLASSES_IN_USE) begin
      classes_in_use <= pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    if (32'(classes_in_use) > CLASSES) begin
      n_eff = NCLS_W'(CLASSES);
    end else begin
      n_eff = NCLS_W'(classes_in_use);
    end
  end

  assign item_ready = (state == S_IDLE);
  assign accept = item_valid && item_ready;
  assign tally_start = accept && (item.mode == MODE_CLASSIFY);

  assign load_ok = (32'(item.class_select) < CLASSES) &&
                   (32'(item.formula_select) < FORMULAS_PER_CLASS) &&
                   (32'(item.clause_select) < CLAUSES_PER_FORMULA);
  assign load_fslot = FSLOT_W'(32'(item.class_select) * FORMULAS_PER_CLASS +
                               32'(item.formula_select));

  assign wr_all = (state == S_CLEAR);
  assign wr_en = wr_all || (accept && item.mode == MODE_LOAD && load_ok);
  assign wr_addr = wr_all ? addr : load_fslot;
  assign wr_entry = wr_all ? '0 : {item.clause_used,
                                   item.negative_mask[ATTRIBUTES-1:0],
                                   item.positive_mask[ATTRIBUTES-1:0]};
  assign wr_present = wr_all ? 1'b0 : item.formula_present;

  assign issue_tag.valid = (state == S_ISSUE);
  assign issue_tag.class_end = (32'(frm) == FORMULAS_PER_CLASS - 1);
  assign issue_tag.item_end = issue_tag.class_end && (32'(cls) == 32'(ncls) - 1);

  assign best_class_ext = 32'(best_class);
  assign best_votes_ext = 32'(best_votes);
  assign out_free = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      addr <= '0;
      frm <= '0;
      cls <= '0;
      ncls <= '0;
      res_class <= '0;
      res_votes <= '0;
      res_load <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          if (32'(addr) == FORMULA_SLOTS - 1) begin
            addr <= '0;
            state <= S_IDLE;
          end else begin
            addr <= addr + FSLOT_W'(1);
          end
        end
        S_IDLE: begin
          if (accept) begin
            addr <= '0;
            frm <= '0;
            cls <= '0;
            ncls <= n_eff;
            res_class <= '0;
            res_votes <= '0;
            if (item.mode == MODE_LOAD) begin
              res_load <= 1'b1;
              state <= S_FINISH;
            end else begin
              res_load <= 1'b0;
              if (n_eff == '0) begin
                state <= S_FINISH;
              end else begin
                state <= S_ISSUE;
              end
            end
          end
        end
        S_ISSUE: begin
          addr <= addr + FSLOT_W'(1);
          if (issue_tag.class_end) begin
            frm <= '0;
            cls <= cls + CLS_W'(1);
          end else begin
            frm <= frm + FRM_W'(1);
          end
          if (issue_tag.item_end) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (tally_done) begin
            res_class <= best_class_ext[2:0];
            res_votes <= best_votes_ext[3:0];
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept && item.mode == MODE_CLASSIFY) begin
      row <= item.row_bits[ATTRIBUTES-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == S_FINISH && out_free) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FINISH && out_free) begin
      result.winning_class <= res_class;
      result.winning_votes <= res_votes;
      result.was_load <= res_load;
    end
  end

  crvc_clause_bank #(
    .ATTRIBUTES(ATTRIBUTES),
    .CLAUSES(CLAUSES_PER_FORMULA),
    .SLOTS(FORMULA_SLOTS)
  ) u_bank (
    .clk(clk),
    .rst(rst),
    .wr_en(wr_en),
    .wr_all(wr_all),
    .wr_addr(wr_addr),
    .wr_clause(item.clause_select),
    .wr_entry(wr_entry),
    .wr_present(wr_present),
    .rd_addr(addr),
    .rd_tag(issue_tag),
    .rd_rows(bank_rows),
    .rd_present(bank_present),
    .rd_tag_q(bank_tag)
  );

  crvc_formula_eval #(
    .ATTRIBUTES(ATTRIBUTES),
    .CLAUSES(CLAUSES_PER_FORMULA)
  ) u_eval (
    .clk(clk),
    .rst(rst),
    .row(row),
    .rows(bank_rows),
    .present(bank_present),
    .in_tag(bank_tag),
    .holds(holds),
    .out_tag(eval_tag)
  );

  crvc_vote_tally #(
    .CLASSES(CLASSES),
    .FORMULAS_PER_CLASS(FORMULAS_PER_CLASS)
  ) u_tally (
    .clk(clk),
    .rst(rst),
    .start(tally_start),
    .in_tag(eval_tag),
    .holds(holds),
    .done(tally_done),
    .best_class(best_class),
    .best_votes(best_votes)
  );

endmodule

/* tb/sv/tb_cnf_rule_vote_classifier_unit.sv */
// Self-checking testbench for cnf_rule_vote_classifier_unit: clause loads and row votes are
// driven through the item channel and checked against an in-bench vote predictor.
// Depends on crvc_pkg and the cnf_rule_vote_classifier_unit RTL.
module tb_cnf_rule_vote_classifier_unit;
  import crvc_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD = 400;
  localparam int TAIL_CYCLES = 80;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  crvc_item_t item = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  crvc_result_t result;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  cnf_rule_vote_classifier_unit dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  logic [63:0] pos_store [512];
  logic [63:0] neg_store [512];
  logic used_flag [512];
  logic present_flag [64];
  logic [3:0] classes_cfg = CLASSES_IN_USE_RESET;

  crvc_item_t pending_items [$];
  crvc_result_t expected_votes [$];
  int errors = 0;
  bit calm = 1'b0;
  int hold_requests = 0;
  int holds_done = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  crvc_result_t want;

  initial begin
    for (int i = 0; i < 512; i++) used_flag[i] = 1'b0;
    for (int i = 0; i < 64; i++) present_flag[i] = 1'b0;
  end

  function automatic bit formula_met(int fslot, logic [63:0] row);
    int k;
    for (int c = 0; c < 8; c++) begin
      k = fslot * 8 + c;
      if (used_flag[k] && (((row & pos_store[k]) | (~row & neg_store[k])) == 64'd0))
        return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic crvc_result_t score_item(crvc_item_t it);
    crvc_result_t r;
    int fslot;
    int n;
    int votes;
    int best;
    int best_votes;
    r = '0;
    if (it.mode == MODE_LOAD) begin
      fslot = it.class_select * 8 + it.formula_select;
      pos_store[fslot * 8 + it.clause_select] = it.positive_mask;
      neg_store[fslot * 8 + it.clause_select] = it.negative_mask;
      used_flag[fslot * 8 + it.clause_select] = it.clause_used;
      present_flag[fslot] = it.formula_present;
      r.was_load = 1'b1;
      return r;
    end
    n = (classes_cfg > 4'd8) ? 8 : int'(classes_cfg);
    best = 0;
    best_votes = 0;
    for (int i = 0; i < n; i++) begin
      votes = 0;
      for (int f = 0; f < 8; f++)
        if (present_flag[i * 8 + f] && formula_met(i * 8 + f, it.row_bits)) votes++;
      if (votes > best_votes) begin
        best_votes = votes;
        best = i;
      end
    end
    r.winning_class = best[2:0];
    r.winning_votes = best_votes[3:0];
    r.was_load = 1'b0;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || item_ready) begin
      if (item_valid) expected_votes.push_back(score_item(item));
      if (send_gap > 0) begin
        send_gap--;
        item_valid <= 1'b0;
      end else if (pending_items.size() > 0 && !calm && $urandom_range(0, 5) == 0) begin
        send_gap = $urandom_range(0, 2);
        item_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        item <= pending_items.pop_front();
        item_valid <= 1'b1;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (expected_votes.size() == 0) begin
          $error("result item with no expectation waiting");
          errors++;
        end else begin
          want = expected_votes.pop_front();
          if (result.winning_class !== want.winning_class) begin
            $error("winning_class expected %0d got %0d", want.winning_class,
                   result.winning_class);
            errors++;
          end
          if (result.winning_votes !== want.winning_votes) begin
            $error("winning_votes expected %0d got %0d", want.winning_votes,
                   result.winning_votes);
            errors++;
          end
          if (result.was_load !== want.was_load) begin
            $error("was_load expected %0d got %0d", want.was_load, result.was_load);
            errors++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else if (holds_done < hold_requests) begin
        holds_done++;
        hold_left = LONG_HOLD - 1;
        result_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        result_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        recv_gap = $urandom_range(0, 2);
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((item_valid && item_ready) || (result_valid && result_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_cnf_rule_vote_classifier_unit: done, errors");
      $finish;
    end
  end

  task automatic write_classes(logic [3:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_CLASSES_IN_USE, 2'b00};
    pwdata <= {28'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    classes_cfg = value;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_items.size() > 0 || item_valid || expected_votes.size() > 0)
      @(posedge clk);
  endtask

  task automatic add_load(int cl, int fo, int cs, logic [63:0] pm, logic [63:0] nm,
                          bit used, bit present);
    crvc_item_t it;
    it = '0;
    it.mode = MODE_LOAD;
    it.class_select = cl[2:0];
    it.formula_select = fo[2:0];
    it.clause_select = cs[2:0];
    it.positive_mask = pm;
    it.negative_mask = nm;
    it.clause_used = used;
    it.formula_present = present;
    pending_items.push_back(it);
  endtask

  task automatic add_classify(logic [63:0] row);
    crvc_item_t it;
    it = '0;
    it.mode = MODE_CLASSIFY;
    it.row_bits = row;
    pending_items.push_back(it);
  endtask

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] rand_mask();
    logic [63:0] m;
    m = '0;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        for (int b = 0; b < $urandom_range(1, 3); b++) m[$urandom_range(0, 63)] = 1'b1;
      end
      5, 6: m = rand_word();
      7: m = rand_word() & rand_word() & rand_word();
      8: m = '0;
      default: m = '1;
    endcase
    return m;
  endfunction

  function automatic logic [63:0] rand_row();
    case ($urandom_range(0, 5))
      0, 1: return rand_word();
      2: return rand_word() & rand_word();
      3: return rand_word() | rand_word();
      4: return ($urandom_range(0, 1) == 0) ? 64'd0 : '1;
      default: return rand_word() ^ (64'd1 << $urandom_range(0, 63));
    endcase
  endfunction

  task automatic add_random(int count);
    crvc_item_t it;
    for (int i = 0; i < count; i++) begin
      it.class_select = 3'($urandom_range(0, 7));
      it.formula_select = 3'($urandom_range(0, 7));
      it.clause_select = 3'($urandom_range(0, 7));
      it.positive_mask = rand_mask();
      it.negative_mask = rand_mask();
      it.clause_used = 1'($urandom_range(0, 2) != 0);
      it.formula_present = 1'($urandom_range(0, 4) != 0);
      it.row_bits = rand_row();
      it.mode = ($urandom_range(0, 99) < 55) ? MODE_LOAD : MODE_CLASSIFY;
      pending_items.push_back(it);
    end
  endtask

  initial begin
    logic [3:0] phase_cfg [6];
    phase_cfg = '{4'd8, 4'd3, 4'd1, 4'd15, 4'd5, 4'd8};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    write_classes(4'd8);

    add_classify(64'd0);
    add_load(3, 0, 0, '1, '0, 1'b1, 1'b1);
    add_classify('1);
    add_classify(64'd0);
    add_load(5, 7, 7, '0, '1, 1'b1, 1'b1);
    add_classify(64'd0);
    add_classify('1);
    add_load(1, 2, 0, '1, '1, 1'b0, 1'b1);
    add_classify(64'd0);
    add_load(1, 3, 4, '0, '0, 1'b1, 1'b1);
    add_classify(64'h5555_aaaa_0f0f_f0f0);
    add_load(1, 2, 1, '0, '0, 1'b0, 1'b0);
    add_classify(64'd0);
    for (int f = 0; f < 8; f++) add_load(7, f, 0, 64'd0, 64'd0, 1'b0, 1'b1);
    add_classify('1);
    wait_idle();

    write_classes(4'd0);
    add_classify('1);
    wait_idle();
    write_classes(4'd15);
    add_classify(64'd0);
    wait_idle();
    write_classes(4'd1);
    add_classify(64'd0);
    wait_idle();

    for (int p = 0; p < 6; p++) begin
      if (p == 4) phase_cfg[p] = 4'($urandom_range(2, 7));
      write_classes(phase_cfg[p]);
      if (p == 5) calm = 1'b1;
      if (p == 0) hold_requests++;
      add_random(p == 0 ? 150 : 120);
      wait_idle();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb_cnf_rule_vote_classifier_unit: done, clean");
    end else begin
      $display("tb_cnf_rule_vote_classifier_unit: done, errors");
    end
    $finish;
  end

endmodule
